### design/irpd_pkg.sv
// irpd_pkg: shared types, codes and reset constants for the ir pulse-distance decoder
// no dependencies; used by every other design file except irpd_out_if
`default_nettype none

package irpd_pkg;

  localparam int FRAME_BITS_DEF     = 32;
  localparam int INTERVAL_WIDTH_DEF = 19;
  localparam int CFG_INDEX_W        = 4;
  localparam int NUM_WIN            = 4;
  localparam int BYTE_W             = 8;
  localparam logic [BYTE_W-1:0] CHECK_ALL_ONES = 8'hFF;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEADER_A_MIN = 4'd0,
    REG_LEADER_A_MAX = 4'd1,
    REG_LEADER_B_MIN = 4'd2,
    REG_LEADER_B_MAX = 4'd3,
    REG_ZERO_MIN     = 4'd4,
    REG_ZERO_MAX     = 4'd5,
    REG_ONE_MIN      = 4'd6,
    REG_ONE_MAX      = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WIN_LEAD_A = 2'd0,
    WIN_LEAD_B = 2'd1,
    WIN_ZERO   = 2'd2,
    WIN_ONE    = 2'd3
  } win_t;

  localparam logic [31:0] RST_LEADER_A_MIN = 32'd218918;
  localparam logic [31:0] RST_LEADER_A_MAX = 32'd267567;
  localparam logic [31:0] RST_LEADER_B_MIN = 32'd328377;
  localparam logic [31:0] RST_LEADER_B_MAX = 32'd401350;
  localparam logic [31:0] RST_ZERO_MIN     = 32'd27364;
  localparam logic [31:0] RST_ZERO_MAX     = 32'd33445;
  localparam logic [31:0] RST_ONE_MIN      = 32'd54729;
  localparam logic [31:0] RST_ONE_MAX      = 32'd66891;

  // window hits for the interval of one event
  typedef struct packed {
    logic lead_a;
    logic lead_b;
    logic zero;
    logic one;
  } win_match_t;

endpackage

`default_nettype wire

### design/irpd_in_if.sv
// irpd_in_if: event channel (edge or timeout with interval) with valid/ready
// depends on irpd_pkg
`default_nettype none

interface irpd_in_if #(
  parameter int INTERVAL_WIDTH = irpd_pkg::INTERVAL_WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [INTERVAL_WIDTH-1:0] interval_ticks;

  modport source (output valid, output req_type, output interval_ticks, input ready);
  modport sink   (input valid, input req_type, input interval_ticks, output ready);
endinterface

`default_nettype wire

### design/irpd_out_if.sv
// irpd_out_if: decoded frame channel with valid/ready
// no dependencies
`default_nettype none

interface irpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] address_byte;
  logic [7:0] address_second_byte;
  logic [7:0] command_byte;
  logic [7:0] command_check_byte;
  logic       frame_format;

  modport source (
    output valid, output address_byte, output address_second_byte,
    output command_byte, output command_check_byte, output frame_format,
    input ready
  );
  modport sink (
    input valid, input address_byte, input address_second_byte,
    input command_byte, input command_check_byte, input frame_format,
    output ready
  );
endinterface

`default_nettype wire

### design/irpd_cfg_regs.sv
// irpd_cfg_regs: the eight interval window bound registers, write-only port
// depends on irpd_pkg
`default_nettype none

module irpd_cfg_regs #(
  parameter int INTERVAL_WIDTH = irpd_pkg::INTERVAL_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [irpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [INTERVAL_WIDTH-1:0]          cfg_data,
  output      logic [INTERVAL_WIDTH-1:0]          win_min [irpd_pkg::NUM_WIN],
  output      logic [INTERVAL_WIDTH-1:0]          win_max [irpd_pkg::NUM_WIN]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_min[irpd_pkg::WIN_LEAD_A] <= irpd_pkg::RST_LEADER_A_MIN[INTERVAL_WIDTH-1:0];
      win_max[irpd_pkg::WIN_LEAD_A] <= irpd_pkg::RST_LEADER_A_MAX[INTERVAL_WIDTH-1:0];
      win_min[irpd_pkg::WIN_LEAD_B] <= irpd_pkg::RST_LEADER_B_MIN[INTERVAL_WIDTH-1:0];
      win_max[irpd_pkg::WIN_LEAD_B] <= irpd_pkg::RST_LEADER_B_MAX[INTERVAL_WIDTH-1:0];
      win_min[irpd_pkg::WIN_ZERO]   <= irpd_pkg::RST_ZERO_MIN[INTERVAL_WIDTH-1:0];
      win_max[irpd_pkg::WIN_ZERO]   <= irpd_pkg::RST_ZERO_MAX[INTERVAL_WIDTH-1:0];
      win_min[irpd_pkg::WIN_ONE]    <= irpd_pkg::RST_ONE_MIN[INTERVAL_WIDTH-1:0];
      win_max[irpd_pkg::WIN_ONE]    <= irpd_pkg::RST_ONE_MAX[INTERVAL_WIDTH-1:0];
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        irpd_pkg::REG_LEADER_A_MIN: win_min[irpd_pkg::WIN_LEAD_A] <= cfg_data;
        irpd_pkg::REG_LEADER_A_MAX: win_max[irpd_pkg::WIN_LEAD_A] <= cfg_data;
        irpd_pkg::REG_LEADER_B_MIN: win_min[irpd_pkg::WIN_LEAD_B] <= cfg_data;
        irpd_pkg::REG_LEADER_B_MAX: win_max[irpd_pkg::WIN_LEAD_B] <= cfg_data;
        irpd_pkg::REG_ZERO_MIN:     win_min[irpd_pkg::WIN_ZERO]   <= cfg_data;
        irpd_pkg::REG_ZERO_MAX:     win_max[irpd_pkg::WIN_ZERO]   <= cfg_data;
        irpd_pkg::REG_ONE_MIN:      win_min[irpd_pkg::WIN_ONE]    <= cfg_data;
        irpd_pkg::REG_ONE_MAX:      win_max[irpd_pkg::WIN_ONE]    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/irpd_window_match.sv
// irpd_window_match: compares one interval against the four inclusive windows
// depends on irpd_pkg
`default_nettype none

module irpd_window_match #(
  parameter int INTERVAL_WIDTH = irpd_pkg::INTERVAL_WIDTH_DEF
) (
  input  wire logic [INTERVAL_WIDTH-1:0] interval_ticks,
  input  wire logic [INTERVAL_WIDTH-1:0] win_min [irpd_pkg::NUM_WIN],
  input  wire logic [INTERVAL_WIDTH-1:0] win_max [irpd_pkg::NUM_WIN],
  output      irpd_pkg::win_match_t      match
);

  logic [irpd_pkg::NUM_WIN-1:0] hit;

  // an empty window (min above max) never hits
  always_comb begin
    for (int k = 0; k < irpd_pkg::NUM_WIN; k++) begin
      hit[k] = (interval_ticks >= win_min[k]) && (interval_ticks <= win_max[k]);
    end
  end

  assign match.lead_a = hit[irpd_pkg::WIN_LEAD_A];
  assign match.lead_b = hit[irpd_pkg::WIN_LEAD_B];
  assign match.zero   = hit[irpd_pkg::WIN_ZERO];
  assign match.one    = hit[irpd_pkg::WIN_ONE];

endmodule

`default_nettype wire

### design/irpd_frame_fsm.sv
// irpd_frame_fsm: phase machine, bit shifter, check byte test and result register
// depends on irpd_pkg and irpd_out_if
`default_nettype none

module irpd_frame_fsm #(
  parameter int FRAME_BITS = irpd_pkg::FRAME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire logic                 item_timeout,
  input  wire irpd_pkg::win_match_t match,
  output      logic                 advance,
  irpd_out_if.source                frame
);

  localparam int CNT_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam int EXT_W = (FRAME_BITS < 32) ? 32 : FRAME_BITS;

  irpd_pkg::phase_t phase, phase_next;
  logic [CNT_W-1:0]      bits_received, bits_received_next;
  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;
  logic                  format_seen, format_seen_next;
  logic                  out_load;
  logic                  fire;
  logic [EXT_W-1:0]      shift_ext;

  assign advance = !frame.valid || frame.ready;
  assign fire    = item_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= irpd_pkg::PH_IDLE;
      bits_received <= '0;
      frame_shift   <= '0;
      format_seen   <= 1'b0;
    end else begin
      phase         <= phase_next;
      bits_received <= bits_received_next;
      frame_shift   <= frame_shift_next;
      format_seen   <= format_seen_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    bits_received_next = bits_received;
    frame_shift_next   = frame_shift;
    format_seen_next   = format_seen;
    out_load           = 1'b0;
    shift_ext          = EXT_W'(frame_shift);
    if (fire) begin
      if (item_timeout) begin
        phase_next = irpd_pkg::PH_IDLE;
      end else begin
        unique case (phase)
          irpd_pkg::PH_LEADER: begin
            if (match.lead_a || match.lead_b) begin
              // window A wins when both hit
              format_seen_next   = !match.lead_a;
              phase_next         = irpd_pkg::PH_DATA;
              bits_received_next = '0;
              frame_shift_next   = '0;
            end else begin
              phase_next = irpd_pkg::PH_IDLE;
            end
          end
          irpd_pkg::PH_DATA: begin
            if (match.zero || match.one) begin
              // lsb first: new bit enters at the top
              frame_shift_next   = {!match.zero, frame_shift[FRAME_BITS-1:1]};
              bits_received_next = bits_received + CNT_W'(1);
              shift_ext          = EXT_W'(frame_shift_next);
              if (bits_received == CNT_W'(FRAME_BITS - 1)) begin
                phase_next = irpd_pkg::PH_IDLE;
                out_load   = (shift_ext[31:24] ^ shift_ext[23:16]) == irpd_pkg::CHECK_ALL_ONES;
              end
            end else begin
              phase_next = irpd_pkg::PH_IDLE;
            end
          end
          // idle and the unused code both just arm
          default: phase_next = irpd_pkg::PH_LEADER;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (out_load) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      frame.address_byte        <= shift_ext[7:0];
      frame.address_second_byte <= shift_ext[15:8];
      frame.command_byte        <= shift_ext[23:16];
      frame.command_check_byte  <= shift_ext[31:24];
      frame.frame_format        <= format_seen;
    end
  end

`ifndef SYNTH
  a_timeout_idles: assert property (@(posedge clk) disable iff (rst)
    fire && item_timeout |=> phase == irpd_pkg::PH_IDLE)
    else $error("timeout did not return to idle");

  a_leader_starts_frame: assert property (@(posedge clk) disable iff (rst)
    fire && !item_timeout && phase == irpd_pkg::PH_LEADER && (match.lead_a || match.lead_b)
    |=> phase == irpd_pkg::PH_DATA && bits_received == '0 && frame_shift == '0)
    else $error("leader match did not start a clean frame");

  a_result_after_data: assert property (@(posedge clk) disable iff (rst)
    $rose(frame.valid) |-> $past(phase) == irpd_pkg::PH_DATA && phase == irpd_pkg::PH_IDLE)
    else $error("frame emitted outside the last data bit");

  a_no_load_when_blocked: assert property (@(posedge clk) disable iff (rst)
    frame.valid && !frame.ready |-> !out_load && phase_next == phase)
    else $error("state moved while result stalled");
`endif

endmodule

`default_nettype wire

### design/ir_remote_pulse_distance_decoder_unit.sv
// ir_remote_pulse_distance_decoder_unit: top level of the ir pulse-distance frame decoder
// depends on irpd_pkg, irpd_in_if, irpd_out_if, irpd_cfg_regs, irpd_window_match,
// irpd_frame_fsm
//
//   port    dir  kind          carries
//   evt     in   valid/ready   req_type, interval_ticks (edge interval or timeout)
//   frame   out  valid/ready   four frame bytes and the leader format
//   cfg_*   in   write only    window bound registers, index 0..7
//
// one event per clock when frame is not stalled; an event is registered in the input
// register on acceptance and decoded from there, so a frame passes from the input
// register into the result register after its last data bit is accepted
// the state only moves while the result register is free or being drained,
// so a stalled frame holds the input register and then evt.ready
// synchronous reset restores the window defaults and returns to idle
`default_nettype none

module ir_remote_pulse_distance_decoder_unit #(
  parameter int FRAME_BITS     = irpd_pkg::FRAME_BITS_DEF,
  parameter int INTERVAL_WIDTH = irpd_pkg::INTERVAL_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  irpd_in_if.sink                               evt,
  irpd_out_if.source                            frame,
  input  wire logic                             cfg_wr_en,
  input  wire logic [irpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [INTERVAL_WIDTH-1:0]        cfg_data
);

  logic                      item_valid;
  logic                      item_timeout;
  logic [INTERVAL_WIDTH-1:0] item_interval;
  logic                      advance;
  logic [INTERVAL_WIDTH-1:0] win_min [irpd_pkg::NUM_WIN];
  logic [INTERVAL_WIDTH-1:0] win_max [irpd_pkg::NUM_WIN];
  irpd_pkg::win_match_t      match;

  assign evt.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      item_timeout  <= evt.req_type;
      item_interval <= evt.interval_ticks;
    end
  end

  irpd_cfg_regs #(
    .INTERVAL_WIDTH(INTERVAL_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win_min   (win_min),
    .win_max   (win_max)
  );

  irpd_window_match #(
    .INTERVAL_WIDTH(INTERVAL_WIDTH)
  ) u_match (
    .interval_ticks (item_interval),
    .win_min        (win_min),
    .win_max        (win_max),
    .match          (match)
  );

  irpd_frame_fsm #(
    .FRAME_BITS(FRAME_BITS)
  ) u_fsm (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_timeout (item_timeout),
    .match        (match),
    .advance      (advance),
    .frame        (frame)
  );

endmodule

`default_nettype wire

### bench/tb_ir_remote_pulse_distance_decoder_unit.sv
// self-checking bench for the ir pulse-distance frame decoder: timed edge events go in,
// decoded frames come out and are matched against a behavioral decoder kept in the bench
// depends on irpd_pkg, irpd_in_if, irpd_out_if and ir_remote_pulse_distance_decoder_unit
`timescale 1ns / 100ps

module tb_ir_remote_pulse_distance_decoder_unit;
  import irpd_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int IW           = INTERVAL_WIDTH_DEF;
  localparam int FRAME_BITS   = FRAME_BITS_DEF;
  localparam int TICK_MAX     = (1 << IW) - 1;
  localparam int NUM_CFG_REGS = 8;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 800;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_INDEX_W-1:0] UNUSED_REG_INDEX = 4'd15;

  typedef struct packed {
    logic          is_timeout;
    logic [IW-1:0] ticks;
  } ir_evt_t;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] address_second_byte;
    logic [7:0] command_byte;
    logic [7:0] command_check_byte;
    logic       frame_format;
  } ir_frame_t;

  typedef enum {
    FLAW_NONE,
    FLAW_CHECK,
    FLAW_LEADER,
    FLAW_DATA,
    FLAW_TIMEOUT
  } frame_flaw_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [IW-1:0]          cfg_data;

  irpd_in_if #(.INTERVAL_WIDTH(IW)) evt_ch ();
  irpd_out_if frame_ch ();

  ir_remote_pulse_distance_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt_ch),
    .frame     (frame_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // decoder state mirrored in the bench
  logic [IW-1:0]         win_bound [NUM_CFG_REGS];
  phase_t                rx_phase  = PH_IDLE;
  int                    rx_bits   = 0;
  logic [FRAME_BITS-1:0] rx_shift  = '0;
  logic                  rx_format = 1'b0;

  ir_evt_t   pending_events [$];
  ir_frame_t expected_frames [$];

  int src_max_gap = 0;
  int snk_max_gap = 0;
  int src_wait = 0;
  int snk_wait = 0;
  int hold_requests = 0;
  int hold_done = 0;
  int hold_left = 0;
  logic src_next_valid;
  logic snk_next_ready;
  ir_evt_t offered;

  int events_sent = 0;
  int timeouts_sent = 0;
  int frames_checked = 0;
  int mismatch_count = 0;
  int window_sets = 0;
  int cycle_count = 0;

  function automatic logic in_win(input logic [IW-1:0] v, input cfg_reg_t lo_reg,
                                  input cfg_reg_t hi_reg);
    return v >= win_bound[lo_reg] && v <= win_bound[hi_reg];
  endfunction

  function automatic logic win_empty(input cfg_reg_t lo_reg, input cfg_reg_t hi_reg);
    return win_bound[lo_reg] > win_bound[hi_reg];
  endfunction

  // advance the mirrored decoder by one accepted transaction
  function automatic void decode_event(input ir_evt_t e);
    logic      data_bit;
    ir_frame_t f;
    if (e.is_timeout) begin
      rx_phase = PH_IDLE;
    end else if (rx_phase == PH_LEADER) begin
      if (in_win(e.ticks, REG_LEADER_A_MIN, REG_LEADER_A_MAX)) begin
        rx_format = 1'b0;
        rx_phase  = PH_DATA;
      end else if (in_win(e.ticks, REG_LEADER_B_MIN, REG_LEADER_B_MAX)) begin
        rx_format = 1'b1;
        rx_phase  = PH_DATA;
      end else begin
        rx_phase = PH_IDLE;
      end
      rx_bits  = 0;
      rx_shift = '0;
    end else if (rx_phase != PH_DATA) begin
      rx_phase = PH_LEADER;
    end else if (in_win(e.ticks, REG_ZERO_MIN, REG_ZERO_MAX) ||
                 in_win(e.ticks, REG_ONE_MIN, REG_ONE_MAX)) begin
      // zero window wins where the two overlap
      data_bit = !in_win(e.ticks, REG_ZERO_MIN, REG_ZERO_MAX);
      rx_shift = {data_bit, rx_shift[FRAME_BITS-1:1]};
      rx_bits++;
      if (rx_bits == FRAME_BITS) begin
        rx_phase = PH_IDLE;
        if ((rx_shift[31:24] ^ rx_shift[23:16]) == CHECK_ALL_ONES) begin
          f.address_byte        = rx_shift[7:0];
          f.address_second_byte = rx_shift[15:8];
          f.command_byte        = rx_shift[23:16];
          f.command_check_byte  = rx_shift[31:24];
          f.frame_format        = rx_format;
          expected_frames.push_back(f);
        end
      end
    end else begin
      rx_phase = PH_IDLE;
    end
  endfunction

  // event driver
  always @(posedge clk) begin
    if (rst) begin
      evt_ch.valid <= 1'b0;
      src_wait = 0;
    end else begin
      src_next_valid = evt_ch.valid;
      if (evt_ch.valid && evt_ch.ready) begin
        decode_event(offered);
        events_sent++;
        if (offered.is_timeout) timeouts_sent++;
        src_next_valid = 1'b0;
        src_wait = $urandom_range(0, src_max_gap);
      end
      if (!src_next_valid) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (pending_events.size() > 0) begin
          offered = pending_events.pop_front();
          evt_ch.req_type       <= offered.is_timeout;
          evt_ch.interval_ticks <= offered.ticks;
          src_next_valid = 1'b1;
        end
      end
      evt_ch.valid <= src_next_valid;
    end
  end

  // frame monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.ready <= 1'b0;
      snk_wait = 0;
      hold_left = 0;
    end else begin
      snk_next_ready = frame_ch.ready;
      if (frame_ch.valid && frame_ch.ready) begin
        frames_checked++;
        if (expected_frames.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: frame with none expected: %02h %02h %02h %02h fmt %0d", $time,
                     frame_ch.address_byte, frame_ch.address_second_byte,
                     frame_ch.command_byte, frame_ch.command_check_byte,
                     frame_ch.frame_format);
          mismatch_count++;
        end else begin
          ir_frame_t want;
          want = expected_frames.pop_front();
          if (frame_ch.address_byte !== want.address_byte ||
              frame_ch.address_second_byte !== want.address_second_byte ||
              frame_ch.command_byte !== want.command_byte ||
              frame_ch.command_check_byte !== want.command_check_byte ||
              frame_ch.frame_format !== want.frame_format) begin
            if (mismatch_count < 10)
              $display("%0t: exp %02h %02h %02h %02h/%0d got %02h %02h %02h %02h/%0d",
                       $time, want.address_byte, want.address_second_byte,
                       want.command_byte, want.command_check_byte, want.frame_format,
                       frame_ch.address_byte, frame_ch.address_second_byte,
                       frame_ch.command_byte, frame_ch.command_check_byte,
                       frame_ch.frame_format);
            mismatch_count++;
          end
        end
        snk_next_ready = 1'b0;
        snk_wait = $urandom_range(0, snk_max_gap);
      end
      if (hold_done != hold_requests) begin
        hold_left = HOLD_CYCLES;
        hold_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        snk_next_ready = 1'b0;
      end else if (!snk_next_ready) begin
        if (snk_wait > 0) snk_wait--;
        else snk_next_ready = 1'b1;
      end
      frame_ch.ready <= snk_next_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d events queued, %0d frames outstanding",
               cycle_count, pending_events.size(), expected_frames.size());
      $display("tb_ir_remote_pulse_distance_decoder_unit NOT OK");
      $finish;
    end
  end

  task automatic push_edge(input int unsigned ticks);
    ir_evt_t e;
    e.is_timeout = 1'b0;
    e.ticks      = IW'(ticks);
    pending_events.push_back(e);
  endtask

  task automatic push_timeout();
    ir_evt_t e;
    e.is_timeout = 1'b1;
    e.ticks      = IW'($urandom_range(0, TICK_MAX));
    pending_events.push_back(e);
  endtask

  function automatic logic [IW-1:0] pick_in(input cfg_reg_t lo_reg, input cfg_reg_t hi_reg);
    logic [IW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = win_bound[lo_reg];
      1: v = win_bound[hi_reg];
      default: v = IW'(win_bound[lo_reg] +
                       $urandom_range(0, win_bound[hi_reg] - win_bound[lo_reg]));
    endcase
    return v;
  endfunction

  // mostly keep clear of the higher-priority window, now and then land in the overlap
  function automatic logic [IW-1:0] pick_data(input logic want_one);
    logic          one_val;
    logic [IW-1:0] v;
    one_val = want_one || win_empty(REG_ZERO_MIN, REG_ZERO_MAX);
    if (one_val && win_empty(REG_ONE_MIN, REG_ONE_MAX)) one_val = 1'b0;
    if (!one_val) begin
      v = pick_in(REG_ZERO_MIN, REG_ZERO_MAX);
    end else begin
      v = pick_in(REG_ONE_MIN, REG_ONE_MAX);
      if ($urandom_range(0, 15) != 0)
        repeat (8) if (in_win(v, REG_ZERO_MIN, REG_ZERO_MAX)) v = pick_in(REG_ONE_MIN, REG_ONE_MAX);
    end
    return v;
  endfunction

  function automatic logic [IW-1:0] pick_outside();
    logic [IW-1:0] v;
    v = IW'($urandom_range(0, TICK_MAX));
    repeat (16)
      if (in_win(v, REG_LEADER_A_MIN, REG_LEADER_A_MAX) ||
          in_win(v, REG_LEADER_B_MIN, REG_LEADER_B_MAX) ||
          in_win(v, REG_ZERO_MIN, REG_ZERO_MAX) || in_win(v, REG_ONE_MIN, REG_ONE_MAX))
        v = IW'($urandom_range(0, TICK_MAX));
    return v;
  endfunction

  task automatic queue_frame(input frame_flaw_t flaw);
    logic [7:0]    cmd;
    logic [31:0]   payload;
    logic          use_b;
    logic [IW-1:0] v;
    int            cut_at;
    cmd     = 8'($urandom_range(0, 255));
    payload = {~cmd, cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    if (flaw == FLAW_CHECK) payload[31:24] = payload[31:24] ^ (8'd1 << $urandom_range(0, 7));
    cut_at = (flaw == FLAW_DATA || flaw == FLAW_TIMEOUT) ? $urandom_range(0, 31) : FRAME_BITS;
    if ($urandom_range(0, 3) != 0) push_timeout();
    push_edge($urandom_range(0, TICK_MAX));
    if (flaw == FLAW_LEADER) begin
      push_edge(pick_outside());
    end else begin
      use_b = 1'($urandom_range(0, 1));
      if (win_empty(REG_LEADER_A_MIN, REG_LEADER_A_MAX)) use_b = 1'b1;
      else if (win_empty(REG_LEADER_B_MIN, REG_LEADER_B_MAX)) use_b = 1'b0;
      if (use_b) begin
        v = pick_in(REG_LEADER_B_MIN, REG_LEADER_B_MAX);
        if ($urandom_range(0, 15) != 0)
          repeat (8)
            if (in_win(v, REG_LEADER_A_MIN, REG_LEADER_A_MAX))
              v = pick_in(REG_LEADER_B_MIN, REG_LEADER_B_MAX);
      end else begin
        v = pick_in(REG_LEADER_A_MIN, REG_LEADER_A_MAX);
      end
      push_edge(v);
      for (int i = 0; i < FRAME_BITS && i <= cut_at; i++) begin
        if (i == cut_at) begin
          if (flaw == FLAW_DATA) push_edge(pick_outside());
          else push_timeout();
        end else begin
          push_edge(pick_data(payload[i]));
        end
      end
    end
  endtask

  task automatic queue_noise(input int count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        push_timeout();
      end else begin
        case ($urandom_range(0, 5))
          0: push_edge(0);
          1: push_edge(TICK_MAX);
          default: push_edge($urandom_range(0, TICK_MAX));
        endcase
      end
    end
  endtask

  task automatic queue_frames(input int count);
    frame_flaw_t flaw;
    repeat (count) begin
      if ($urandom_range(0, 5) == 0) queue_noise($urandom_range(2, 8));
      case ($urandom_range(0, 9))
        7: flaw = FLAW_CHECK;
        8: flaw = FLAW_LEADER;
        9: flaw = ($urandom_range(0, 1) != 0) ? FLAW_DATA : FLAW_TIMEOUT;
        default: flaw = FLAW_NONE;
      endcase
      queue_frame(flaw);
    end
  endtask

  // block is idle once nothing is queued or expected and the pipeline has emptied
  task automatic wait_until_drained();
    @(negedge clk);
    while (pending_events.size() > 0 || evt_ch.valid || expected_frames.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [IW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx <= REG_ONE_MAX) win_bound[idx] = val;
  endtask

  task automatic load_windows(input int unsigned a_lo, a_hi, b_lo, b_hi,
                              input int unsigned z_lo, z_hi, o_lo, o_hi);
    write_reg(REG_LEADER_A_MIN, IW'(a_lo));
    write_reg(REG_LEADER_A_MAX, IW'(a_hi));
    write_reg(REG_LEADER_B_MIN, IW'(b_lo));
    write_reg(REG_LEADER_B_MAX, IW'(b_hi));
    write_reg(REG_ZERO_MIN, IW'(z_lo));
    write_reg(REG_ZERO_MAX, IW'(z_hi));
    write_reg(REG_ONE_MIN, IW'(o_lo));
    write_reg(REG_ONE_MAX, IW'(o_hi));
    // writes to an unused index must not disturb any window
    write_reg(UNUSED_REG_INDEX, IW'($urandom_range(0, TICK_MAX)));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    window_sets++;
  endtask

  task automatic load_random_windows();
    int unsigned z_lo, z_hi, o_lo, o_hi, a_lo, a_hi, b_lo, b_hi;
    z_lo = $urandom_range(0, 20000);
    z_hi = z_lo + $urandom_range(0, 6000);
    o_lo = z_hi + 1 + $urandom_range(0, 4000);
    o_hi = o_lo + $urandom_range(0, 12000);
    a_lo = o_hi + 1 + $urandom_range(0, 50000);
    a_hi = a_lo + $urandom_range(0, 60000);
    b_lo = a_hi + 1 + $urandom_range(0, 30000);
    b_hi = b_lo + $urandom_range(0, 80000);
    load_windows(a_lo, a_hi, b_lo, b_hi, z_lo, z_hi, o_lo, o_hi);
  endtask

  initial begin
    evt_ch.valid          = 1'b0;
    evt_ch.req_type       = 1'b0;
    evt_ch.interval_ticks = '0;
    frame_ch.ready        = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_index             = REG_LEADER_A_MIN;
    cfg_data              = '0;
    win_bound[REG_LEADER_A_MIN] = RST_LEADER_A_MIN[IW-1:0];
    win_bound[REG_LEADER_A_MAX] = RST_LEADER_A_MAX[IW-1:0];
    win_bound[REG_LEADER_B_MIN] = RST_LEADER_B_MIN[IW-1:0];
    win_bound[REG_LEADER_B_MAX] = RST_LEADER_B_MAX[IW-1:0];
    win_bound[REG_ZERO_MIN]     = RST_ZERO_MIN[IW-1:0];
    win_bound[REG_ZERO_MAX]     = RST_ZERO_MAX[IW-1:0];
    win_bound[REG_ONE_MIN]      = RST_ONE_MIN[IW-1:0];
    win_bound[REG_ONE_MAX]      = RST_ONE_MAX[IW-1:0];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset windows: timeouts in every phase, extreme intervals, edges of each window
    src_max_gap = 10;
    snk_max_gap = 10;
    push_timeout();
    push_edge(0);
    push_edge(TICK_MAX);
    push_edge(TICK_MAX);
    push_timeout();
    push_edge(0);
    push_edge(win_bound[REG_LEADER_A_MIN]);
    push_edge(win_bound[REG_ZERO_MIN]);
    push_edge(win_bound[REG_ONE_MAX]);
    push_timeout();
    push_edge(0);
    push_edge(win_bound[REG_LEADER_B_MAX]);
    push_edge(win_bound[REG_ZERO_MAX]);
    push_edge(win_bound[REG_ONE_MIN]);
    push_edge(TICK_MAX);
    push_edge(0);
    push_timeout();
    queue_frames(8);
    wait_until_drained();

    // overlapping windows: leader a and the zero bit take precedence
    load_windows(200000, 260000, 240000, 300000, 20000, 40000, 35000, 60000);
    src_max_gap = 0;
    snk_max_gap = 0;
    push_timeout();
    push_edge(0);
    push_edge(250000);
    push_edge(38000);
    push_edge(40000);
    push_timeout();
    queue_frames(4);
    wait_until_drained();

    // register extremes
    load_windows(TICK_MAX, TICK_MAX, 0, TICK_MAX - 1, 0, 0, 1, TICK_MAX);
    src_max_gap = 3;
    snk_max_gap = 10;
    queue_frames(5);
    wait_until_drained();

    // empty leader a and zero windows never match
    load_windows(5000, 4000, 6000, 7000, 300, 250, 100, 200);
    src_max_gap = 10;
    snk_max_gap = 0;
    push_edge(0);
    push_edge(4500);
    push_edge(0);
    push_edge(6500);
    push_edge(275);
    queue_frames(2);
    wait_until_drained();

    repeat (2) begin
      load_random_windows();
      src_max_gap = $urandom_range(0, 10);
      snk_max_gap = $urandom_range(0, 10);
      queue_frames(5);
      wait_until_drained();
    end

    // back to defaults; receiver holds off while events keep coming
    load_windows(RST_LEADER_A_MIN, RST_LEADER_A_MAX, RST_LEADER_B_MIN, RST_LEADER_B_MAX,
                 RST_ZERO_MIN, RST_ZERO_MAX, RST_ONE_MIN, RST_ONE_MAX);
    src_max_gap = 0;
    snk_max_gap = 0;
    hold_requests++;
    queue_frames(6);
    wait_until_drained();

    src_max_gap = 10;
    snk_max_gap = 10;
    queue_frames(4);
    wait_until_drained();

    $display("drove %0d events (%0d timeouts) under %0d window settings", events_sent,
             timeouts_sent, window_sets);
    $display("checked %0d decoded frames, %0d mismatches", frames_checked, mismatch_count);
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("tb_ir_remote_pulse_distance_decoder_unit OK");
    end else begin
      $display("tb_ir_remote_pulse_distance_decoder_unit NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
design/irpd_pkg.sv
design/irpd_in_if.sv
design/irpd_out_if.sv
design/irpd_cfg_regs.sv
design/irpd_window_match.sv
design/irpd_frame_fsm.sv
design/ir_remote_pulse_distance_decoder_unit.sv
bench/tb_ir_remote_pulse_distance_decoder_unit.sv
